/* hdl/lkrp_pkg.sv */
// Shared request codes and controller/datapath handshake types for the LRU-K victim selector.
package lkrp_pkg;

    localparam logic [1:0] OP_RECORD = 2'd0;
    localparam logic [1:0] OP_MARK   = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_EVICT  = 2'd3;

    localparam logic [3:0] HIST_DEPTH_RESET    = 4'd2;
    localparam logic [6:0] ACTIVE_FRAMES_RESET = 7'd64;

    localparam logic CFG_HIST_DEPTH    = 1'b0;
    localparam logic CFG_ACTIVE_FRAMES = 1'b1;

    typedef struct packed {
        logic accept;
        logic scan_start;
        logic clear;
        logic exec;
        logic pick;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic scan_done;
    } status_t;

endpackage

/* hdl/lru_k_replacement_policy.sv */
// Top level of the LRU-K victim selector: controller, datapath and ports.
//
// Each accepted item yields exactly one result item. After reset the block
// first sweeps its frame metadata memory, one frame per cycle, and accepts
// no item until that pass is done; configuration writes are taken at any
// time. A record, mark or remove item reads the frame's metadata from memory
// on acceptance, then updates it (and, for a record, writes the access
// stamp), then loads the output register. An evict item scans every frame
// through a three-stage pipeline (metadata read, key stamp read, compare
// against the oldest history and oldest cache keys seen so far), one frame
// per cycle; the metadata memory's single read port sets that rate. The
// result sits in an output register, so a new item is accepted while the
// previous result still waits under out_stall. Records to frames at or above
// active_frames do not advance the stamp clock.
module lru_k_replacement_policy #(
    parameter int FRAMES      = 64,
    parameter int HIST_DEPTH  = 8,
    parameter int STAMP_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_index,
    input  logic [6:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] op,
    input  logic [5:0] frame_num,
    input  logic       evictable_value,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       victim_valid,
    output logic [5:0] victim_frame,
    output logic [6:0] evictable_count,
    output logic       stamp_exhausted
);

    lkrp_pkg::cmd_t    cmd;
    lkrp_pkg::status_t st;

    // The controller sequences each item; the datapath owns all storage.
    lkrp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .st        (st)
    );

    lkrp_dp #(
        .FRAMES      (FRAMES),
        .HIST_DEPTH  (HIST_DEPTH),
        .STAMP_WIDTH (STAMP_WIDTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .op              (op),
        .frame_num       (frame_num),
        .evictable_value (evictable_value),
        .cmd             (cmd),
        .st              (st),
        .victim_valid    (victim_valid),
        .victim_frame    (victim_frame),
        .evictable_count (evictable_count),
        .stamp_exhausted (stamp_exhausted)
    );

endmodule

/* hdl/lkrp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lkrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/lkrp_ctrl.sv */
// Request sequencer: clearing pass, request execution, victim scan and result hand-off.
module lkrp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        op,
    output logic              out_valid,
    input  logic              out_stall,
    output lkrp_pkg::cmd_t    cmd,
    input  lkrp_pkg::status_t st
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_EXEC  = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_PICK  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (st.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (op == lkrp_pkg::OP_EVICT)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_DONE;
            end
            ST_SCAN:
            begin
                if (st.scan_done)
                begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                cmd.pick   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_load_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> (state_reg == ST_IDLE) && out_valid_reg)
        else $error("result load did not return to idle with a valid result");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> (state_reg == ST_EXEC) || (state_reg == ST_SCAN))
        else $error("accepted item did not start work");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg)
        else $error("stalled result was dropped");

endmodule

/* hdl/lkrp_dp.sv */
// Datapath: frame metadata and stamp memories, stamp clock, victim scan pipeline, result registers.
module lkrp_dp #(
    parameter int FRAMES      = 64,
    parameter int HIST_DEPTH  = 8,
    parameter int STAMP_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic              cfg_index,
    input  logic [6:0]        cfg_data,
    input  logic [1:0]        op,
    input  logic [5:0]        frame_num,
    input  logic              evictable_value,
    input  lkrp_pkg::cmd_t    cmd,
    output lkrp_pkg::status_t st,
    output logic              victim_valid,
    output logic [5:0]        victim_frame,
    output logic [6:0]        evictable_count,
    output logic              stamp_exhausted
);

    localparam int FW = $clog2(FRAMES);
    localparam int SW = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int CW = $clog2(HIST_DEPTH + 1);
    localparam int TW = $clog2(FRAMES + 1);
    localparam int IW = (FW > 6) ? FW : 6;
    localparam int XW = (TW > 7) ? TW : 7;
    localparam int MW = CW + SW + 3;
    localparam logic [STAMP_WIDTH-1:0] STAMP_MAX = {STAMP_WIDTH{1'b1}};
    localparam logic [FW-1:0] LAST_FRAME = FW'(FRAMES - 1);

    typedef struct packed {
        logic [CW-1:0] cnt;
        logic [SW-1:0] head;
        logic          hist;
        logic          cache;
        logic          ev;
    } meta_t;

    // Configuration.
    logic [3:0] hist_depth_reg;
    logic [6:0] active_frames_reg;

    // Request.
    logic [1:0]    req_op_reg;
    logic [FW-1:0] req_idx_reg;
    logic          req_ok_reg;
    logic          req_rec_ok_reg;
    logic          req_ev_reg;

    // Global state.
    logic [STAMP_WIDTH-1:0] clock_reg;
    logic [STAMP_WIDTH-1:0] clock_next;
    logic                   ovf_reg;
    logic                   ovf_next;
    logic [TW-1:0]          total_reg;
    logic [TW-1:0]          total_next;
    logic [FW-1:0]          clr_idx_reg;

    // Scan pipeline.
    logic                   scan_issue_reg;
    logic [FW-1:0]          scan_ptr_reg;
    logic                   s1_valid_reg;
    logic [FW-1:0]          s1_idx_reg;
    logic                   s2_valid_reg;
    logic [FW-1:0]          s2_idx_reg;
    logic                   s2_hist_reg;
    logic                   s2_cache_reg;
    logic                   hfound_reg;
    logic [FW-1:0]          hidx_reg;
    logic [STAMP_WIDTH-1:0] hbest_reg;
    logic                   cfound_reg;
    logic [FW-1:0]          cidx_reg;
    logic [STAMP_WIDTH-1:0] cbest_reg;

    // Results.
    logic          res_vvalid_reg;
    logic [FW-1:0] res_vidx_reg;
    logic          out_vvalid_reg;
    logic [5:0]    out_vframe_reg;
    logic [6:0]    out_count_reg;
    logic          out_ovf_reg;

    // Memory ports.
    logic                   meta_we;
    logic [FW-1:0]          meta_waddr;
    meta_t                  meta_wdata;
    logic [FW-1:0]          meta_raddr;
    meta_t                  meta_rd;
    logic                   stamp_we;
    logic [FW+SW-1:0]       stamp_waddr;
    logic [FW+SW-1:0]       stamp_raddr;
    logic [STAMP_WIDTH-1:0] stamp_rdata;

    logic [IW-1:0] fid_wide;
    logic [FW-1:0] fid_idx;
    logic          fid_ok;
    logic [CW-1:0] eff_k;
    logic [CW-1:0] ring_len;
    logic [SW-1:0] ring_pos;
    meta_t         rec_meta;
    logic          tick;
    logic          total_inc;
    logic          total_dec;
    logic          pick_found;
    logic [FW-1:0] pick_idx;
    logic [IW-1:0] vframe_wide;
    logic [XW-1:0] total_wide;

    assign fid_wide = IW'(frame_num);
    assign fid_idx  = fid_wide[FW-1:0];
    assign fid_ok   = (32'(frame_num) < FRAMES);

    assign pick_found = hfound_reg || cfound_reg;
    assign pick_idx   = hfound_reg ? hidx_reg : cidx_reg;

    assign st.clear_last = (clr_idx_reg == LAST_FRAME);
    assign st.scan_done  = s2_valid_reg && (s2_idx_reg == LAST_FRAME);

    always_comb
    begin
        if (hist_depth_reg == 4'd0)
        begin
            eff_k = CW'(1);
        end
        else if (32'(hist_depth_reg) > HIST_DEPTH)
        begin
            eff_k = CW'(HIST_DEPTH);
        end
        else
        begin
            eff_k = CW'(hist_depth_reg);
        end
    end

    assign meta_raddr  = scan_issue_reg ? scan_ptr_reg : fid_idx;
    assign stamp_raddr = {s1_idx_reg, meta_rd.head};

    // Update of one frame's record on an access.
    always_comb
    begin
        rec_meta = meta_rd;
        ring_len = (meta_rd.cnt == '0) ? CW'(1) : meta_rd.cnt;
        ring_pos = (32'(meta_rd.head) >= 32'(ring_len)) ? '0 : meta_rd.head;
        stamp_we    = 1'b0;
        stamp_waddr = {req_idx_reg, ring_pos};
        if (meta_rd.cache)
        begin
            if (32'(ring_pos) + 1 == 32'(ring_len))
            begin
                rec_meta.head = '0;
            end
            else
            begin
                rec_meta.head = SW'(32'(ring_pos) + 1);
            end
            stamp_we = cmd.exec && (req_op_reg == lkrp_pkg::OP_RECORD) && req_rec_ok_reg;
        end
        else
        begin
            if (!meta_rd.hist)
            begin
                rec_meta.hist = 1'b1;
                rec_meta.cnt  = '0;
                rec_meta.head = '0;
            end
            if (32'(rec_meta.cnt) < HIST_DEPTH)
            begin
                stamp_waddr  = {req_idx_reg, SW'(rec_meta.cnt)};
                stamp_we     = cmd.exec && (req_op_reg == lkrp_pkg::OP_RECORD) && req_rec_ok_reg;
                rec_meta.cnt = rec_meta.cnt + CW'(1);
            end
            if ((rec_meta.cnt >= eff_k) || (32'(rec_meta.cnt) >= HIST_DEPTH))
            begin
                rec_meta.hist  = 1'b0;
                rec_meta.cache = 1'b1;
                rec_meta.head  = '0;
            end
        end
    end

    always_comb
    begin
        meta_we    = 1'b0;
        meta_waddr = req_idx_reg;
        meta_wdata = meta_rd;
        tick       = 1'b0;
        total_inc  = 1'b0;
        total_dec  = 1'b0;
        if (cmd.clear)
        begin
            meta_we    = 1'b1;
            meta_waddr = clr_idx_reg;
            meta_wdata = '0;
        end
        else if (cmd.exec)
        begin
            case (req_op_reg)
                lkrp_pkg::OP_RECORD:
                begin
                    if (req_rec_ok_reg)
                    begin
                        tick       = 1'b1;
                        meta_we    = 1'b1;
                        meta_wdata = rec_meta;
                    end
                end
                lkrp_pkg::OP_MARK:
                begin
                    tick = 1'b1;
                    if (req_ok_reg)
                    begin
                        if (req_ev_reg)
                        begin
                            if ((meta_rd.hist || meta_rd.cache) && !meta_rd.ev)
                            begin
                                meta_we       = 1'b1;
                                meta_wdata.ev = 1'b1;
                                total_inc     = 1'b1;
                            end
                        end
                        else if (meta_rd.ev)
                        begin
                            meta_we       = 1'b1;
                            meta_wdata.ev = 1'b0;
                            total_dec     = 1'b1;
                        end
                    end
                end
                lkrp_pkg::OP_REMOVE:
                begin
                    tick = 1'b1;
                    if (req_ok_reg)
                    begin
                        meta_we    = 1'b1;
                        meta_wdata = '0;
                        total_dec  = meta_rd.ev;
                    end
                end
                default:
                begin
                    tick = 1'b0;
                end
            endcase
        end
        else if (cmd.pick)
        begin
            tick = 1'b1;
            if (pick_found)
            begin
                meta_we    = 1'b1;
                meta_waddr = pick_idx;
                meta_wdata = '0;
                total_dec  = 1'b1;
            end
        end
    end

    always_comb
    begin
        clock_next = clock_reg;
        ovf_next   = ovf_reg;
        if (tick)
        begin
            if (clock_reg != STAMP_MAX)
            begin
                clock_next = clock_reg + STAMP_WIDTH'(1);
            end
            if (clock_next == STAMP_MAX)
            begin
                ovf_next = 1'b1;
            end
        end
        total_next = total_reg;
        if (total_inc)
        begin
            total_next = total_reg + TW'(1);
        end
        else if (total_dec)
        begin
            total_next = total_reg - TW'(1);
        end
    end

    assign vframe_wide = IW'(res_vidx_reg);
    assign total_wide  = XW'(total_reg);

    lkrp_ram #(
        .WIDTH (MW),
        .DEPTH (FRAMES)
    ) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .raddr (meta_raddr),
        .rdata (meta_rd)
    );

    lkrp_ram #(
        .WIDTH (STAMP_WIDTH),
        .DEPTH (FRAMES << SW)
    ) u_stamp_ram (
        .clk   (clk),
        .we    (stamp_we),
        .waddr (stamp_waddr),
        .wdata (clock_reg),
        .raddr (stamp_raddr),
        .rdata (stamp_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_depth_reg    <= lkrp_pkg::HIST_DEPTH_RESET;
            active_frames_reg <= lkrp_pkg::ACTIVE_FRAMES_RESET;
            clock_reg         <= '0;
            ovf_reg           <= 1'b0;
            total_reg         <= '0;
            clr_idx_reg       <= '0;
            scan_issue_reg    <= 1'b0;
            scan_ptr_reg      <= '0;
            s1_valid_reg      <= 1'b0;
            s2_valid_reg      <= 1'b0;
            hfound_reg        <= 1'b0;
            cfound_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == lkrp_pkg::CFG_HIST_DEPTH)
                begin
                    hist_depth_reg <= cfg_data[3:0];
                end
                else
                begin
                    active_frames_reg <= cfg_data;
                end
            end
            clock_reg <= clock_next;
            ovf_reg   <= ovf_next;
            total_reg <= total_next;
            if (cmd.clear)
            begin
                clr_idx_reg <= clr_idx_reg + FW'(1);
            end
            if (cmd.scan_start)
            begin
                scan_issue_reg <= 1'b1;
                scan_ptr_reg   <= '0;
                hfound_reg     <= 1'b0;
                cfound_reg     <= 1'b0;
            end
            else if (scan_issue_reg)
            begin
                scan_ptr_reg <= scan_ptr_reg + FW'(1);
                if (scan_ptr_reg == LAST_FRAME)
                begin
                    scan_issue_reg <= 1'b0;
                end
            end
            s1_valid_reg <= scan_issue_reg;
            s2_valid_reg <= s1_valid_reg;
            if (s2_valid_reg)
            begin
                if (s2_hist_reg && (!hfound_reg || (stamp_rdata < hbest_reg)))
                begin
                    hfound_reg <= 1'b1;
                end
                if (s2_cache_reg && (!cfound_reg || (stamp_rdata < cbest_reg)))
                begin
                    cfound_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_op_reg     <= op;
            req_idx_reg    <= fid_idx;
            req_ok_reg     <= fid_ok;
            req_rec_ok_reg <= fid_ok && ({1'b0, frame_num} < active_frames_reg);
            req_ev_reg     <= evictable_value;
        end
        s1_idx_reg   <= scan_ptr_reg;
        s2_idx_reg   <= s1_idx_reg;
        s2_hist_reg  <= meta_rd.hist && meta_rd.ev;
        s2_cache_reg <= meta_rd.cache && meta_rd.ev;
        if (s2_valid_reg && s2_hist_reg && (!hfound_reg || (stamp_rdata < hbest_reg)))
        begin
            hbest_reg <= stamp_rdata;
            hidx_reg  <= s2_idx_reg;
        end
        if (s2_valid_reg && s2_cache_reg && (!cfound_reg || (stamp_rdata < cbest_reg)))
        begin
            cbest_reg <= stamp_rdata;
            cidx_reg  <= s2_idx_reg;
        end
        if (cmd.exec)
        begin
            res_vvalid_reg <= 1'b0;
            res_vidx_reg   <= '0;
        end
        else if (cmd.pick)
        begin
            res_vvalid_reg <= pick_found;
            res_vidx_reg   <= pick_found ? pick_idx : '0;
        end
        if (cmd.load_out)
        begin
            out_vvalid_reg <= res_vvalid_reg;
            out_vframe_reg <= vframe_wide[5:0];
            out_count_reg  <= total_wide[6:0];
            out_ovf_reg    <= ovf_reg;
        end
    end

    assign victim_valid    = out_vvalid_reg;
    assign victim_frame    = out_vframe_reg;
    assign evictable_count = out_count_reg;
    assign stamp_exhausted = out_ovf_reg;

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(total_reg) <= FRAMES)
        else $error("evictable total exceeds frame count");

    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |=> ovf_reg)
        else $error("stamp exhausted flag dropped");

    a_scan_drained: assert property (@(posedge clk) disable iff (!rst_n)
        st.scan_done |-> !scan_issue_reg && !s1_valid_reg)
        else $error("scan finished with reads still in flight");

endmodule

/* tb/tb.sv */
// Self-checking testbench for the LRU-K victim selector.
`timescale 1ns / 100ps

module tb;

    localparam int NFRAMES = 64;
    localparam int KMAX = 8;
    localparam int LIMIT_CYCLES = 1500000;
    localparam int WANT_DEPTH = 4096;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic       cfg_index = 1'b0;
    logic [6:0] cfg_data = '0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [1:0] op = '0;
    logic [5:0] frame_num = '0;
    logic       evictable_value = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       victim_valid;
    logic [5:0] victim_frame;
    logic [6:0] evictable_count;
    logic       stamp_exhausted;

    lru_k_replacement_policy dut (.*);

    // Clock with a 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // One result item as the checker compares it.
    typedef struct packed {
        logic       vvalid;
        logic [5:0] vframe;
        logic [6:0] count;
        logic       exhausted;
    } verdict_t;

    // Shadow copy of the selector state, kept at the block's widths.
    logic [31:0] stamps [NFRAMES][KMAX];
    logic [3:0]  hits [NFRAMES];
    logic [2:0]  head [NFRAMES];
    logic        hist_q [NFRAMES];
    logic        cache_q [NFRAMES];
    logic        evict_q [NFRAMES];
    logic [31:0] clock_q;
    logic [6:0]  total_q;
    logic        sticky_q;
    logic [3:0]  k_reg;
    logic [6:0]  active_reg;

    // Expected results in order of acceptance, as a ring.
    verdict_t want_mem [WANT_DEPTH];
    int sent_n = 0;
    int seen_n = 0;
    int errors = 0;
    int cycles = 0;

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        errors++;
    endtask

    function automatic void shadow_reset();
        for (int f = 0; f < NFRAMES; f++)
        begin
            hits[f] = '0;
            head[f] = '0;
            hist_q[f] = 1'b0;
            cache_q[f] = 1'b0;
            evict_q[f] = 1'b0;
            for (int j = 0; j < KMAX; j++)
                stamps[f][j] = '0;
        end
        clock_q = '0;
        total_q = '0;
        sticky_q = 1'b0;
        k_reg = lkrp_pkg::HIST_DEPTH_RESET;
        active_reg = lkrp_pkg::ACTIVE_FRAMES_RESET;
    endfunction

    function automatic void advance_clock();
        if (clock_q != 32'hFFFF_FFFF)
            clock_q++;
        if (clock_q == 32'hFFFF_FFFF)
            sticky_q = 1'b1;
    endfunction

    function automatic void forget_frame(input int f);
        if (evict_q[f])
        begin
            evict_q[f] = 1'b0;
            total_q--;
        end
        hist_q[f] = 1'b0;
        cache_q[f] = 1'b0;
        hits[f] = '0;
        head[f] = '0;
    endfunction

    function automatic void note_access(input int f);
        logic [31:0] s;
        int n;
        int h;
        int k;
        s = clock_q;
        k = (k_reg == 0) ? 1 : ((k_reg > KMAX) ? KMAX : k_reg);
        advance_clock();
        if (cache_q[f])
        begin
            n = (hits[f] == 0) ? 1 : hits[f];
            h = (head[f] >= n) ? 0 : head[f];
            stamps[f][h] = s;
            head[f] = 3'((h + 1) % n);
            return;
        end
        if (!hist_q[f])
        begin
            hist_q[f] = 1'b1;
            hits[f] = '0;
            head[f] = '0;
        end
        if (hits[f] < KMAX)
        begin
            stamps[f][hits[f]] = s;
            hits[f]++;
        end
        if (hits[f] >= k || hits[f] >= KMAX)
        begin
            hist_q[f] = 1'b0;
            cache_q[f] = 1'b1;
            head[f] = '0;
        end
    endfunction

    // Oldest key among evictable frames of one class; ties go to the lowest frame.
    function automatic bit oldest_in_class(input bit want_cache, output int who);
        bit found;
        logic [31:0] best;
        logic [31:0] key;
        found = 1'b0;
        best = '0;
        who = 0;
        for (int f = 0; f < NFRAMES; f++)
        begin
            if (!(want_cache ? cache_q[f] : hist_q[f]) || !evict_q[f])
                continue;
            key = stamps[f][head[f]];
            if (!found || key < best)
            begin
                found = 1'b1;
                best = key;
                who = f;
            end
        end
        return found;
    endfunction

    function automatic verdict_t predict_verdict(input logic [1:0] o, input int f,
                                                 input logic ev);
        verdict_t v;
        int who;
        bit hit;
        int lim;
        who = 0;
        hit = 1'b0;
        lim = (active_reg < NFRAMES) ? active_reg : NFRAMES;
        case (o)
            lkrp_pkg::OP_RECORD:
                if (f < lim)
                    note_access(f);
            lkrp_pkg::OP_MARK:
            begin
                advance_clock();
                if (ev)
                begin
                    if ((hist_q[f] || cache_q[f]) && !evict_q[f])
                    begin
                        evict_q[f] = 1'b1;
                        total_q++;
                    end
                end
                else if (evict_q[f])
                begin
                    evict_q[f] = 1'b0;
                    total_q--;
                end
            end
            lkrp_pkg::OP_REMOVE:
            begin
                advance_clock();
                forget_frame(f);
            end
            default:
            begin
                advance_clock();
                hit = oldest_in_class(1'b0, who);
                if (!hit)
                    hit = oldest_in_class(1'b1, who);
                if (hit)
                    forget_frame(who);
                else
                    who = 0;
            end
        endcase
        v.vvalid = hit;
        v.vframe = who[5:0];
        v.count = total_q;
        v.exhausted = sticky_q;
        return v;
    endfunction

    // Sends one item after a random gap; the expectation is stored on acceptance.
    // Valid stays up after acceptance so the next item can follow with no gap.
    task automatic send_item(input logic [1:0] o, input logic [5:0] f, input logic ev);
        int gap;
        gap = $urandom_range(0, 16);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        frame_num <= f;
        evictable_value <= ev;
        do
            @(posedge clk);
        while (in_stall);
        want_mem[sent_n % WANT_DEPTH] = predict_verdict(o, f, ev);
        sent_n++;
    endtask

    // Drops valid and waits until every result is back.
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (seen_n == sent_n);
    endtask

    // Register writes are only made once every result is back.
    task automatic write_reg(input logic idx, input logic [6:0] value);
        drain_results();
        repeat (80) @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == lkrp_pkg::CFG_HIST_DEPTH)
            k_reg = value[3:0];
        else
            active_reg = value;
    endtask

    // Random stall on the result side, drawn per result.
    initial
    begin
        int hold;
        forever
        begin
            @(negedge clk);
            hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // Result checker against the oldest expectation.
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (seen_n == sent_n)
            begin
                report("result items", seen_n + 1, sent_n);
            end
            else
            begin
                want = want_mem[seen_n % WANT_DEPTH];
                seen_n++;
                if (victim_valid !== want.vvalid)
                    report("victim_valid", victim_valid, want.vvalid);
                if (victim_frame !== want.vframe)
                    report("victim_frame", victim_frame, want.vframe);
                if (evictable_count !== want.count)
                    report("evictable_count", evictable_count, want.count);
                if (stamp_exhausted !== want.exhausted)
                    report("stamp_exhausted", stamp_exhausted, want.exhausted);
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    // Edge cases: empty evicts, marks on untracked frames, the last frame, history before cache, removes.
    task automatic test_directed();
        send_item(lkrp_pkg::OP_EVICT, 6'd0, 1'b0);
        send_item(lkrp_pkg::OP_MARK, 6'd5, 1'b1);
        send_item(lkrp_pkg::OP_MARK, 6'd5, 1'b0);
        send_item(lkrp_pkg::OP_RECORD, 6'd0, 1'b0);
        send_item(lkrp_pkg::OP_RECORD, 6'd63, 1'b0);
        send_item(lkrp_pkg::OP_RECORD, 6'd63, 1'b0);
        send_item(lkrp_pkg::OP_RECORD, 6'd7, 1'b0);
        send_item(lkrp_pkg::OP_MARK, 6'd0, 1'b1);
        send_item(lkrp_pkg::OP_MARK, 6'd63, 1'b1);
        send_item(lkrp_pkg::OP_MARK, 6'd7, 1'b1);
        send_item(lkrp_pkg::OP_MARK, 6'd7, 1'b1);
        send_item(lkrp_pkg::OP_EVICT, 6'd0, 1'b0);
        send_item(lkrp_pkg::OP_EVICT, 6'd0, 1'b0);
        send_item(lkrp_pkg::OP_EVICT, 6'd0, 1'b0);
        send_item(lkrp_pkg::OP_EVICT, 6'd0, 1'b0);
        send_item(lkrp_pkg::OP_RECORD, 6'd3, 1'b0);
        send_item(lkrp_pkg::OP_MARK, 6'd3, 1'b1);
        send_item(lkrp_pkg::OP_REMOVE, 6'd3, 1'b0);
        send_item(lkrp_pkg::OP_REMOVE, 6'd42, 1'b1);
    endtask

    // Random traffic: mostly accesses and marks on a small frame pool.
    task automatic test_random(input int count, input int pool);
        int r;
        logic [5:0] f;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            f = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, pool - 1));
            if (r < 45)
                send_item(lkrp_pkg::OP_RECORD, f, 1'($urandom));
            else if (r < 75)
                send_item(lkrp_pkg::OP_MARK, f, ($urandom_range(0, 3) != 0));
            else if (r < 83)
                send_item(lkrp_pkg::OP_REMOVE, f, 1'($urandom));
            else
                send_item(lkrp_pkg::OP_EVICT, 6'($urandom), 1'($urandom));
        end
    endtask

    // Walks several settings of both registers, extremes included.
    task automatic test_settings();
        write_reg(lkrp_pkg::CFG_HIST_DEPTH, 7'd1);
        test_random(250, 8);
        write_reg(lkrp_pkg::CFG_HIST_DEPTH, 7'd8);
        write_reg(lkrp_pkg::CFG_ACTIVE_FRAMES, 7'd1);
        test_random(200, 4);
        write_reg(lkrp_pkg::CFG_ACTIVE_FRAMES, 7'd64);
        test_random(300, 16);
        // Lower k with frames still in history, then odd values.
        write_reg(lkrp_pkg::CFG_HIST_DEPTH, 7'd3);
        test_random(250, 12);
        write_reg(lkrp_pkg::CFG_HIST_DEPTH, 7'd0);
        write_reg(lkrp_pkg::CFG_ACTIVE_FRAMES, 7'd127);
        test_random(200, 64);
        write_reg(lkrp_pkg::CFG_HIST_DEPTH, 7'd15);
        write_reg(lkrp_pkg::CFG_ACTIVE_FRAMES, 7'd20);
        test_random(250, 32);
        // The sender waits for every result before going on.
        drain_results();
        write_reg(lkrp_pkg::CFG_HIST_DEPTH, 7'd2);
        write_reg(lkrp_pkg::CFG_ACTIVE_FRAMES, 7'd40);
        test_random(280, 10);
    endtask

    initial
    begin
        shadow_reset();
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random(200, 6);
        test_settings();
        drain_results();
        repeat (100) @(negedge clk);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
